// ===== hw/rtl/fsip_pkg.sv =====
package fsip_pkg;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharConvC = 8'h63;
  localparam logic [7:0] CharConvD = 8'h64;
  localparam logic [7:0] CharConvX = 8'h78;

  // control from the sequencer to the digit converter
  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic shift;
  } fsip_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'h0, d};
    end else begin
      c = CharLowA + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fsip_conv.sv =====
module fsip_conv import fsip_pkg::*; #(
  parameter int unsigned ArgWidth  = 32,
  parameter int unsigned NumDigits = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsip_ctrl_t          ctrl_i,
  input  logic [ArgWidth-1:0] mag_i,
  output logic                busy_o,
  output logic [3:0]          top_digit_o
);

  localparam int unsigned DigW = NumDigits * 4;
  localparam int unsigned CntW = $clog2(ArgWidth + 1);

  logic [ArgWidth-1:0] bin_q;
  logic [DigW-1:0]     bcd_q;
  logic [DigW-1:0]     adj;
  logic [CntW-1:0]     cnt_q;

  // double dabble: add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load_dec) begin
      cnt_q <= CntW'(ArgWidth);
    end else if (ctrl_i.load_hex) begin
      cnt_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_dec) begin
      bin_q <= mag_i;
      bcd_q <= '0;
    end else if (ctrl_i.load_hex) begin
      bcd_q <= DigW'(mag_i);
    end else if (cnt_q != '0) begin
      bcd_q <= {adj[DigW-2:0], bin_q[ArgWidth-1]};
      bin_q <= {bin_q[ArgWidth-2:0], 1'b0};
    end else if (ctrl_i.shift) begin
      bcd_q <= {bcd_q[DigW-5:0], 4'h0};
    end
  end

  assign busy_o      = (cnt_q != '0);
  assign top_digit_o = bcd_q[DigW-1 -: 4];

endmodule

// ===== hw/rtl/format_string_integer_printer_unit.sv =====
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   fmt_char_i, arg_value_i
// out      output     out_valid_o / out_ready_i out_char_o, last_o
//
// a literal, '%%' or '%c' goes straight into the output register; '%d' runs a bit-serial
// binary to bcd conversion and then a digit sweep, '%x' loads the magnitude into the digit
// register and sweeps it; the digit register sweeps one digit a cycle unless the output stalls.
// reset clears the sequencer, the pending-percent flag and the output valid.
// input is taken only in idle with the output register free; a stalled output holds the
// digit sweep in place, though leading zeros are still dropped.
module format_string_integer_printer_unit import fsip_pkg::*; #(
  parameter int unsigned ARG_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           fmt_char_i,
  input  logic [ARG_WIDTH-1:0] arg_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 last_o
);

  localparam int unsigned NumDigits = ((ARG_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned DCntW     = $clog2(NumDigits + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StConv   = 2'd1;
  localparam logic [1:0] StDigits = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 pending_q, pending_d;
  logic                 lead_q, lead_d;
  logic [DCntW-1:0]     dcnt_q, dcnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load;
  logic                 out_free;
  logic                 in_xfer;
  logic                 neg;
  logic [ARG_WIDTH-1:0] mag;
  logic                 conv_busy;
  logic [3:0]           top_digit;
  fsip_ctrl_t           ctrl;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // most negative value comes out as its unsigned magnitude
  assign neg = arg_value_i[ARG_WIDTH-1];
  assign mag = neg ? (~arg_value_i + 1'b1) : arg_value_i;

  always_comb begin
    state_d    = state_q;
    pending_d  = pending_q;
    lead_d     = lead_q;
    dcnt_d     = dcnt_q;
    out_load   = 1'b0;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    ctrl       = '0;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (pending_q) begin
            pending_d = 1'b0;
            case (fmt_char_i)
              CharPct: begin
                out_load   = 1'b1;
                out_char_d = CharPct;
                out_last_d = 1'b1;
              end
              CharConvC: begin
                out_load   = 1'b1;
                out_char_d = arg_value_i[7:0];
                out_last_d = 1'b1;
              end
              CharConvD, CharConvX: begin
                ctrl.load_dec = (fmt_char_i == CharConvD);
                ctrl.load_hex = (fmt_char_i == CharConvX);
                state_d       = StConv;
                if (neg) begin
                  out_load   = 1'b1;
                  out_char_d = CharMinus;
                  out_last_d = 1'b0;
                end
              end
              default: begin
              end
            endcase
          end else if (fmt_char_i == CharPct) begin
            pending_d = 1'b1;
          end else if (fmt_char_i != CharNul) begin
            out_load   = 1'b1;
            out_char_d = fmt_char_i;
            out_last_d = 1'b1;
          end
        end
      end
      StConv: begin
        if (!conv_busy) begin
          state_d = StDigits;
          dcnt_d  = DCntW'(NumDigits);
          lead_d  = 1'b1;
        end
      end
      StDigits: begin
        if (lead_q && (top_digit == 4'h0) && (dcnt_q > DCntW'(1))) begin
          // drop a leading zero
          ctrl.shift = 1'b1;
          dcnt_d     = dcnt_q - 1'b1;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_char_d = digit_char(top_digit);
          out_last_d = (dcnt_q == DCntW'(1));
          ctrl.shift = 1'b1;
          dcnt_d     = dcnt_q - 1'b1;
          lead_d     = 1'b0;
          if (dcnt_q == DCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pending_q   <= 1'b0;
      lead_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      lead_q      <= lead_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  fsip_conv #(
    .ArgWidth  (ARG_WIDTH),
    .NumDigits (NumDigits)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .mag_i       (mag),
    .busy_o      (conv_busy),
    .top_digit_o (top_digit)
  );

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

// ===== sim/fsip_char_checker.sv =====
module fsip_char_checker import fsip_pkg::*; #(
  parameter int unsigned ARG_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  logic [7:0]           fmt_char_i,
  input  logic [ARG_WIDTH-1:0] arg_value_i,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [7:0]           out_char_o,
  input  logic                 last_o,
  output int                   fail_count_o,
  output int                   awaited_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } term_char_t;

  term_char_t awaited_q[$];
  logic [7:0] line_buf[$];
  logic       conv_armed = 1'b0;
  int         mismatches = 0;

  initial begin
    fail_count_o = 0;
    awaited_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    fail_count_o = mismatches;
    $display("%0t: %s: got %02h, want %02h", $time, what, got, want);
  endtask

  // sign-magnitude digits, most significant first
  function automatic void add_number(input logic [ARG_WIDTH-1:0] raw, input logic [4:0] radix);
    logic [ARG_WIDTH-1:0] mag;
    logic [7:0]           digit;
    logic [7:0]           digits[$];
    mag = raw;
    if (raw[ARG_WIDTH-1]) begin
      line_buf.push_back(CharMinus);
      mag = ~raw + 1'b1;
    end
    if (mag == '0) begin
      line_buf.push_back(CharZero);
    end
    while (mag != '0) begin
      digit = 8'(mag % radix);
      digits.push_front(digit < 8'd10 ? CharZero + digit : CharLowA + digit - 8'd10);
      mag = mag / radix;
    end
    foreach (digits[i]) line_buf.push_back(digits[i]);
  endfunction

  function automatic void predict_line(input logic [7:0] c, input logic [ARG_WIDTH-1:0] arg);
    line_buf.delete();
    if (conv_armed) begin
      conv_armed = 1'b0;
      case (c)
        CharPct:   line_buf.push_back(CharPct);
        CharConvD: add_number(arg, 5'd10);
        CharConvX: add_number(arg, 5'd16);
        CharConvC: line_buf.push_back(arg[7:0]);
        default:   ;  // unknown selector or end of string emits nothing
      endcase
    end else if (c == CharPct) begin
      conv_armed = 1'b1;
    end else if (c != CharNul) begin
      line_buf.push_back(c);
    end
    foreach (line_buf[i]) begin
      awaited_q.push_back('{line_buf[i], i == line_buf.size() - 1});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    term_char_t want;
    if (!rst_ni) begin
      conv_armed = 1'b0;
      awaited_q.delete();
    end else begin
      // an output transfer can never stem from an input taken at the same edge
      if (out_valid_o && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected output char", out_char_o, 8'h00);
        end else begin
          want = awaited_q.pop_front();
          if (out_char_o !== want.ch) begin
            report_mismatch("out_char", out_char_o, want.ch);
          end
          if (last_o !== want.last) begin
            report_mismatch("last", {7'd0, last_o}, {7'd0, want.last});
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_line(fmt_char_i, arg_value_i);
      end
    end
    awaited_o = awaited_q.size();
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import fsip_pkg::*;

  localparam int unsigned ArgW = 32;
  localparam int RandomItems  = 400;
  localparam int QuietTail    = 60;
  localparam int HoldCycles   = 400;
  localparam int HoldAfter    = 150;
  localparam int StallLimit   = 3000;
  localparam int SettleCycles = 120;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      fmt_char = 8'h00;
  logic [ArgW-1:0] arg_value = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [7:0]      out_char;
  logic            out_last;

  int fail_count;
  int awaited_chars;
  int items_sent = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit held_off = 1'b0;

  always #5 clk = ~clk;

  format_string_integer_printer_unit #(.ARG_WIDTH(ArgW)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .fmt_char_i  (fmt_char),
    .arg_value_i (arg_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_char_o  (out_char),
    .last_o      (out_last)
  );

  fsip_char_checker #(.ARG_WIDTH(ArgW)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .fmt_char_i   (fmt_char),
    .arg_value_i  (arg_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_char_o   (out_char),
    .last_o       (out_last),
    .fail_count_o (fail_count),
    .awaited_o    (awaited_chars)
  );

  function automatic logic [ArgW-1:0] rand_arg();
    logic [ArgW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = ArgW'($urandom_range(0, 20));
      1: v = -ArgW'($urandom_range(1, 20));
      2: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(ArgW-1){1'b0}}};
          1: v = {1'b0, {(ArgW-1){1'b1}}};
          2: v = '1;
          default: v = '0;
        endcase
      end
      3: v = (ArgW'(1) << $urandom_range(0, ArgW - 1)) - ArgW'($urandom_range(0, 1));
      default: v = ArgW'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_selector();
    logic [7:0] sel;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: sel = CharConvD;
      4, 5, 6:    sel = CharConvX;
      7, 8:       sel = CharConvC;
      default:    sel = CharPct;
    endcase
    return sel;
  endfunction

  // valid stays up across back-to-back transfers; a gap lowers it for whole cycles
  task automatic send_item(input logic [7:0] ch, input logic [ArgW-1:0] arg);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    fmt_char  <= ch;
    arg_value <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_conversion(input logic [7:0] sel, input logic [ArgW-1:0] arg);
    send_item(CharPct, rand_arg());
    send_item(sel, arg);
  endtask

  task automatic drain_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_chars != 0) @(posedge clk);
  endtask

  // output side: random stalls, one long hold-off to back up the input
  initial begin : sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && items_sent >= HoldAfter) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held_off = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == StallLimit) begin
        $display("format_string_integer_printer_unit verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stim
    int         random_sent;
    int         kind;
    bit         mid_pause_done;
    logic [7:0] ch;
    random_sent = 0;
    mid_pause_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // literals at the byte extremes, end of string while idle, then each selector at edge values
    send_item(8'h01, rand_arg());
    send_item(8'hff, rand_arg());
    send_item(8'h41, rand_arg());
    send_item(CharNul, rand_arg());
    send_conversion(CharPct, rand_arg());
    send_conversion(CharConvD, '0);
    send_conversion(CharConvD, {1'b0, {(ArgW-1){1'b1}}});
    send_conversion(CharConvD, {1'b1, {(ArgW-1){1'b0}}});
    send_conversion(CharConvD, '1);
    send_conversion(CharConvX, {1'b1, {(ArgW-1){1'b0}}});
    send_conversion(CharConvX, '0);
    send_conversion(CharConvX, 32'hdeadbeef);
    send_conversion(CharConvC, 32'hffffff7e);
    // pending percent cut off by end of string, then an unknown selector
    send_conversion(CharNul, rand_arg());
    send_conversion(8'h71, rand_arg());
    drain_output();

    while (random_sent < RandomItems) begin
      if (random_sent >= RandomItems - QuietTail) begin
        quiet = 1'b1;
      end
      if (!mid_pause_done && random_sent >= RandomItems / 2) begin
        drain_output();
        mid_pause_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        ch = 8'($urandom_range(1, 255));
        while (ch == CharPct) ch = 8'($urandom_range(1, 255));
        send_item(ch, rand_arg());
        random_sent += 1;
      end else if (kind < 80) begin
        send_conversion(pick_selector(), rand_arg());
        random_sent += 2;
      end else if (kind < 88) begin
        send_item(CharNul, rand_arg());
        random_sent += 1;
      end else if (kind < 94) begin
        ch = 8'($urandom_range(1, 255));
        while (ch == CharPct || ch == CharConvD || ch == CharConvX || ch == CharConvC) begin
          ch = 8'($urandom_range(1, 255));
        end
        send_conversion(ch, rand_arg());
        random_sent += 2;
      end else begin
        send_conversion(CharNul, rand_arg());
        random_sent += 2;
      end
    end

    drain_output();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("format_string_integer_printer_unit verification clean");
    end else begin
      $display("format_string_integer_printer_unit verification failed");
    end
    $finish;
  end

endmodule
